### rtl/pwmd_pkg.sv
// shared types, constants and helpers for the multichannel pwm pin driver
package pwmd_pkg;

	localparam int CHANNELS = 18;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int PIN_W = 5;
	localparam int DUTY_W = 8;
	localparam int PHASE_W = 8;

	// logical pins 0..17 map onto ports a, c and d
	localparam int NPINS = 18;
	localparam int PORT_C_FIRST = 2;
	localparam int PORT_D_FIRST = 10;
	localparam int PORT_A_W = 3;
	localparam int PORT_CD_W = 8;

	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_CONFIG   = 2'd1,
		OP_SET_DUTY = 2'd2
	} opcode_t;

	// request token that walks the cell row
	typedef struct packed {
		logic                 vld;
		opcode_t              op;
		logic                 ok;
		logic [PIN_W-1:0]     pin;
		logic [DUTY_W-1:0]    duty;
		logic [PHASE_W-1:0]   phase;
		logic [CNT_W-1:0]     used;
		logic [NPINS-1:0]     set;
		logic [NPINS-1:0]     clr;
	} tok_t;

	// one-hot pin select, zero for pins with no port bit
	function automatic logic [NPINS-1:0] pin_onehot(input logic [PIN_W-1:0] p);
		logic [NPINS-1:0] r;
		for (int k = 0; k < NPINS; k++) begin
			r[k] = (p == PIN_W'(k));
		end
		return r;
	endfunction

endpackage

### rtl/pwmd_cell.sv
// one pwm channel: holds pin and duty, updates the passing token
module pwmd_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pwmd_pkg::CNT_W-1:0]  idx,
	input  logic                        adv,
	input  pwmd_pkg::tok_t              tok_in,
	output pwmd_pkg::tok_t              tok_out
);
	import pwmd_pkg::*;

	logic [PIN_W-1:0]  pin_q;
	logic [DUTY_W-1:0] duty_q;
	tok_t              tok_q;
	tok_t              nxt;
	logic              in_use;
	logic              drive;
	logic              high;
	logic [NPINS-1:0]  oh;

	assign in_use = (idx < tok_in.used);
	assign oh = pin_onehot(pin_q);

	// tick drive for this channel
	always_comb begin
		nxt = tok_in;
		high = (tok_in.phase == '0) && (duty_q != '0);
		drive = (tok_in.phase == '0) || (duty_q < tok_in.phase);
		if (tok_in.vld && tok_in.op == OP_TICK && in_use && drive) begin
			if (high) begin
				nxt.set = tok_in.set | oh;
				nxt.clr = tok_in.clr & ~oh;
			end else begin
				nxt.clr = tok_in.clr | oh;
				nxt.set = tok_in.set & ~oh;
			end
		end
	end

	// channel table entry
	always_ff @(posedge clk) begin
		if (adv && tok_in.vld) begin
			if (tok_in.op == OP_CONFIG && tok_in.ok && idx == tok_in.used) begin
				pin_q <= tok_in.pin;
				duty_q <= '0;
			end else if (tok_in.op == OP_SET_DUTY && in_use && pin_q == tok_in.pin) begin
				duty_q <= tok_in.duty;
			end
		end
	end

	// token hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

### rtl/multichannel_pwm_pin_driver_unit.sv
// multichannel pwm pin driver: request entry, cell row and result register
// a request passes the launch register, the cell row and the result register; output back-pressure stalls them all
// only one request is in flight at a time: the token steps one cell per cycle while the output is not stalled
// the next request is taken once the result has moved into the output register
// asynchronous reset clears phase, channel count, tokens and output valid
// the channel table itself is not cleared; only entries below the count are read
module multichannel_pwm_pin_driver_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// opcode[1:0], pin[6:2], duty[14:7], zero[15]
	input  logic [pwmd_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// port_a_set[2:0], port_a_clear[5:3], port_c_set[13:6], port_c_clear[21:14],
	// port_d_set[29:22], port_d_clear[37:30], accepted[38], phase_now[46:39], zero[47]
	output logic [pwmd_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import pwmd_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0]   used_q;
	logic               busy_q;
	tok_t               launch_q;
	tok_t               chain [0:CHANNELS];
	tok_t               tail;
	tok_t               new_tok;
	logic               accept;
	logic               adv;
	logic               room;
	logic [NPINS-1:0]   out_set_q;
	logic [NPINS-1:0]   out_clr_q;
	logic               out_ok_q;
	logic [PHASE_W-1:0] out_phase_q;

	assign s_tready = !busy_q;
	assign accept = s_tvalid && s_tready;
	assign tail = chain[CHANNELS];
	assign adv = !(tail.vld && m_tvalid && !m_tready);
	assign room = (used_q < CNT_W'(CHANNELS));

	// build the token for an incoming request
	always_comb begin
		new_tok = '0;
		new_tok.vld = 1'b1;
		new_tok.op = opcode_t'(s_tdata[1:0]);
		new_tok.pin = s_tdata[6:2];
		new_tok.duty = s_tdata[14:7];
		new_tok.used = used_q;
		new_tok.ok = 1'b1;
		new_tok.phase = phase_q;
		case (new_tok.op)
			OP_TICK: begin
				new_tok.phase = phase_q + PHASE_W'(1);
			end
			OP_CONFIG: begin
				new_tok.ok = room;
				if (room) begin
					new_tok.clr = pin_onehot(s_tdata[6:2]);
				end
			end
			default: begin
			end
		endcase
	end

	// phase, channel count, busy flag and launch token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			used_q <= '0;
			busy_q <= 1'b0;
			launch_q <= '0;
		end else begin
			if (adv) begin
				launch_q <= accept ? new_tok : '0;
			end
			if (accept) begin
				phase_q <= new_tok.phase;
				busy_q <= 1'b1;
				if (new_tok.op == OP_CONFIG && room) begin
					used_q <= used_q + CNT_W'(1);
				end
			end else if (tail.vld && adv) begin
				busy_q <= 1'b0;
			end
		end
	end

	// cell row
	assign chain[0] = launch_q;
	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		pwmd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (CNT_W'(i)),
			.adv     (adv),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (tail.vld && adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.vld && adv) begin
			out_set_q <= tail.set;
			out_clr_q <= tail.clr;
			out_ok_q <= tail.ok;
			out_phase_q <= tail.phase;
		end
	end

	// pack the port masks
	assign m_tdata = {
		1'b0,
		out_phase_q,
		out_ok_q,
		out_clr_q[NPINS-1:PORT_D_FIRST],
		out_set_q[NPINS-1:PORT_D_FIRST],
		out_clr_q[PORT_D_FIRST-1:PORT_C_FIRST],
		out_set_q[PORT_D_FIRST-1:PORT_C_FIRST],
		out_clr_q[PORT_C_FIRST-1:0], 1'b0,
		out_set_q[PORT_C_FIRST-1:0], 1'b0
	};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(CHANNELS))
		else $error("channel count beyond table size");

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!tail.vld && !launch_q.vld))
		else $error("token in flight while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("request accepted without going busy");

	a_mask_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((out_set_q & out_clr_q) == '0))
		else $error("pin both set and cleared");
`endif

endmodule
